>>> design/uer_pkg.sv
// uer_pkg: shared types, register indexes and zone codes for the echo ranger.
// No dependencies; used by every file under design/.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // configuration port
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CFG_TRIGGER_TICKS = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_TIMEOUT_TICKS = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_TICKS_PER_CM  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_FAR_LIMIT     = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_MID_LIMIT     = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_NEAR_LIMIT    = 3'd5;

  localparam logic [7:0]  TriggerTicksRst = 8'd10;
  localparam logic [15:0] TimeoutTicksRst = 16'd30000;
  localparam logic [5:0]  TicksPerCmRst   = 6'd58;
  localparam logic [15:0] FarLimitRst     = 16'd30;
  localparam logic [15:0] MidLimitRst     = 16'd15;
  localparam logic [15:0] NearLimitRst    = 16'd5;

  localparam logic [15:0] Sat16 = 16'hFFFF;

  // zone codes
  localparam logic [2:0] ZONE_CLEAR    = 3'd0;
  localparam logic [2:0] ZONE_APPROACH = 3'd1;
  localparam logic [2:0] ZONE_WARNING  = 3'd2;
  localparam logic [2:0] ZONE_STOP     = 3'd3;
  localparam logic [2:0] ZONE_NONE     = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] timeout_ticks;
    logic [5:0]  ticks_per_cm;
    logic [15:0] far_limit;
    logic [15:0] mid_limit;
    logic [15:0] near_limit;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_word_t;

  typedef struct packed {
    logic        trigger_out;
    logic        busy_res;
    logic        done_res;
    logic [15:0] distance_cm;
    logic        no_object;
    logic [2:0]  zone;
    logic        led_green;
    logic        led_yellow;
    logic        led_red;
  } out_word_t;

endpackage

`default_nettype wire

>>> design/uer_cfg_regs.sv
// uer_cfg_regs: configuration register file written through a plain write port.
// Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [uer_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [uer_pkg::CfgDataBits-1:0] cfg_data_i,
  output uer_pkg::cfg_t                        cfg_o
);

  uer_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        uer_pkg::CFG_TRIGGER_TICKS: cfg_d.trigger_ticks = cfg_data_i[7:0];
        uer_pkg::CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i;
        uer_pkg::CFG_TICKS_PER_CM:  cfg_d.ticks_per_cm  = cfg_data_i[5:0];
        uer_pkg::CFG_FAR_LIMIT:     cfg_d.far_limit     = cfg_data_i;
        uer_pkg::CFG_MID_LIMIT:     cfg_d.mid_limit     = cfg_data_i;
        uer_pkg::CFG_NEAR_LIMIT:    cfg_d.near_limit    = cfg_data_i;
        default: ;  // writes past the list are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= uer_pkg::TriggerTicksRst;
      cfg_q.timeout_ticks <= uer_pkg::TimeoutTicksRst;
      cfg_q.ticks_per_cm  <= uer_pkg::TicksPerCmRst;
      cfg_q.far_limit     <= uer_pkg::FarLimitRst;
      cfg_q.mid_limit     <= uer_pkg::MidLimitRst;
      cfg_q.near_limit    <= uer_pkg::NearLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/uer_core.sv
// uer_core: measurement state machine, tick counters and zone classifier.
// Advances one tick per accepted word; depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_core (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire uer_pkg::cfg_t     cfg_i,
  input  wire uer_pkg::in_word_t in_i,
  output uer_pkg::out_word_t res_o
);

  uer_pkg::phase_e phase_q, phase_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [5:0]  frac_q, frac_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] dist_q, dist_d;
  logic [2:0]  zone_q, zone_d;

  logic        trig, done;
  logic [15:0] el_base, el_inc;
  logic [5:0]  frac_base;
  logic [15:0] cnt_base;
  logic [6:0]  frac_inc;
  uer_pkg::phase_e ph;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == uer_pkg::Sat16) ? v : v + 16'd1;
  endfunction

  function automatic logic [2:0] classify(input logic [15:0] d, input uer_pkg::cfg_t c);
    if (d > c.far_limit)       classify = uer_pkg::ZONE_CLEAR;
    else if (d > c.mid_limit)  classify = uer_pkg::ZONE_APPROACH;
    else if (d > c.near_limit) classify = uer_pkg::ZONE_WARNING;
    else                       classify = uer_pkg::ZONE_STOP;
  endfunction

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    frac_d    = frac_q;
    cnt_d     = cnt_q;
    dist_d    = dist_q;
    zone_d    = zone_q;
    trig      = 1'b0;
    done      = 1'b0;

    // stray codes fall back to idle
    case (phase_q)
      uer_pkg::PH_TRIG, uer_pkg::PH_WAIT, uer_pkg::PH_HIGH: ph = phase_q;
      default: ph = uer_pkg::PH_IDLE;
    endcase

    el_base = elapsed_q;
    if (ph == uer_pkg::PH_IDLE && in_i.start_req) begin
      ph      = uer_pkg::PH_TRIG;
      el_base = '0;
    end
    el_inc = sat_inc(el_base);

    // rising echo in wait restarts the cm counters
    if (ph == uer_pkg::PH_WAIT) begin
      frac_base = '0;
      cnt_base  = '0;
    end else begin
      frac_base = frac_q;
      cnt_base  = cnt_q;
    end
    frac_inc = {1'b0, frac_base} + 7'd1;

    phase_d   = ph;
    elapsed_d = el_base;

    case (ph)
      uer_pkg::PH_TRIG: begin
        trig = 1'b1;
        if (el_inc >= {8'd0, cfg_i.trigger_ticks}) begin
          phase_d   = uer_pkg::PH_WAIT;
          elapsed_d = '0;
        end else begin
          elapsed_d = el_inc;
        end
      end
      uer_pkg::PH_WAIT, uer_pkg::PH_HIGH: begin
        if (ph == uer_pkg::PH_HIGH && !in_i.echo_level) begin
          dist_d  = cnt_q;
          zone_d  = classify(cnt_q, cfg_i);
          phase_d = uer_pkg::PH_IDLE;
          done    = 1'b1;
        end else begin
          if (in_i.echo_level) begin
            phase_d = uer_pkg::PH_HIGH;
            if (frac_inc >= {1'b0, cfg_i.ticks_per_cm}) begin
              frac_d = '0;
              cnt_d  = sat_inc(cnt_base);
            end else begin
              frac_d = frac_inc[5:0];
              cnt_d  = cnt_base;
            end
          end
          elapsed_d = el_inc;
          if (el_inc >= cfg_i.timeout_ticks) begin
            dist_d  = '0;
            zone_d  = uer_pkg::ZONE_NONE;
            phase_d = uer_pkg::PH_IDLE;
            done    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= uer_pkg::PH_IDLE;
      elapsed_q <= '0;
      frac_q    <= '0;
      cnt_q     <= '0;
      dist_q    <= '0;
      zone_q    <= uer_pkg::ZONE_CLEAR;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      frac_q    <= frac_d;
      cnt_q     <= cnt_d;
      dist_q    <= dist_d;
      zone_q    <= zone_d;
    end
  end

  always_comb begin
    res_o.trigger_out = trig;
    res_o.busy_res    = (phase_d != uer_pkg::PH_IDLE);
    res_o.done_res    = done;
    res_o.distance_cm = dist_d;
    res_o.no_object   = (zone_d == uer_pkg::ZONE_NONE);
    res_o.zone        = zone_d;
    res_o.led_green   = (zone_d == uer_pkg::ZONE_APPROACH) ||
                        (zone_d == uer_pkg::ZONE_WARNING) ||
                        (zone_d == uer_pkg::ZONE_STOP);
    res_o.led_yellow  = (zone_d == uer_pkg::ZONE_WARNING) ||
                        (zone_d == uer_pkg::ZONE_STOP);
    res_o.led_red     = (zone_d == uer_pkg::ZONE_STOP);
  end

endmodule

`default_nettype wire

>>> design/ultrasonic_echo_ranger.sv
// ultrasonic_echo_ranger: top level, input handshake, result register.
// Instantiates uer_cfg_regs and uer_core; depends on uer_pkg.
//
// Usage:
//   Each input word is one microsecond tick: start_req asks for a new
//   measurement (ignored while busy), echo_level is the sampled echo pin.
//   Every accepted word produces exactly one result word carrying the
//   trigger drive, busy/done flags, last distance in cm, zone and LEDs.
//   Latency: the result for a word is valid the cycle after it is taken.
//   Throughput: one word per cycle; the state update and result are one
//   pass of logic from the state registers into the result register.
//   Stall: in_ready_o stays high while the result register is empty or
//   being drained; if the receiver holds out_ready_i low with a result
//   pending, input is held off and no ticks advance, so nothing is lost.
//   Reset (rst_ni low, async): config registers return to their defaults
//   (trigger 10, timeout 30000, 58 ticks/cm, limits 30/15/5), the
//   measurement goes idle with distance 0 and zone clear, and no result
//   is pending.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered and
//   should be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [uer_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [uer_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire uer_pkg::in_word_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output uer_pkg::out_word_t                   out_data_o
);

  uer_pkg::cfg_t      cfg;
  uer_pkg::out_word_t res;
  uer_pkg::out_word_t res_q;
  logic               out_valid_q, out_valid_d;
  logic               accept;

  uer_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // core state advances only on an accepted tick
  uer_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .cfg_i  (cfg),
    .in_i   (in_data_i),
    .res_o  (res)
  );

  // free slot when empty or the pending word leaves this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

>>> bench/ultrasonic_echo_ranger_tb.sv
// ultrasonic_echo_ranger_tb: self-checking bench for the echo ranger, with a cycle-true
// tick predictor, a random-gap word driver and a result monitor.
// Depends on uer_pkg and ultrasonic_echo_ranger from design/.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb;

  // random stimulus stops once this many measurement ticks are queued
  localparam int unsigned WorkTicks = 1850;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [uer_pkg::CfgIdxBits-1:0]  cfg_idx_i   = '0;
  logic [uer_pkg::CfgDataBits-1:0] cfg_data_i  = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  uer_pkg::in_word_t               in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  uer_pkg::out_word_t              out_data_o;

  ultrasonic_echo_ranger i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Ranger mirror: register copy plus measurement state, stepped once per
  // accepted tick word.
  // --------------------------------------------------------------------------
  uer_pkg::cfg_t cfg_m = '{
    trigger_ticks: uer_pkg::TriggerTicksRst,
    timeout_ticks: uer_pkg::TimeoutTicksRst,
    ticks_per_cm:  uer_pkg::TicksPerCmRst,
    far_limit:     uer_pkg::FarLimitRst,
    mid_limit:     uer_pkg::MidLimitRst,
    near_limit:    uer_pkg::NearLimitRst
  };
  uer_pkg::phase_e m_phase   = uer_pkg::PH_IDLE;
  logic [15:0]     m_elapsed = '0;
  logic [5:0]      m_frac    = '0;
  logic [15:0]     m_cm      = '0;
  logic [15:0]     m_dist    = '0;
  logic [2:0]      m_zone    = uer_pkg::ZONE_CLEAR;

  uer_pkg::in_word_t  tick_q[$];     // tick words waiting for the driver
  uer_pkg::out_word_t report_q[$];   // expected result words, oldest first
  int unsigned mismatch_n = 0;
  int unsigned work_n     = 0;

  // idle shaping; the limits and hold_go are set by the stimulus process between phases
  int unsigned tx_max  = 0;
  int unsigned rx_max  = 0;
  int unsigned tx_gap  = 0;
  int unsigned rx_stall = 0;
  bit          hold_go = 1'b0;
  bit          rx_hold = 1'b0;

  // zone cascade: far, then mid, then near; limits are used as written
  function automatic logic [2:0] zone_of(logic [15:0] d);
    if (d > cfg_m.far_limit) return uer_pkg::ZONE_CLEAR;
    if (d > cfg_m.mid_limit) return uer_pkg::ZONE_APPROACH;
    if (d > cfg_m.near_limit) return uer_pkg::ZONE_WARNING;
    return uer_pkg::ZONE_STOP;
  endfunction

  function automatic uer_pkg::out_word_t predict_tick(uer_pkg::in_word_t w);
    uer_pkg::out_word_t r;
    logic               trig;
    logic               done;
    trig = 1'b0;
    done = 1'b0;
    if (m_phase == uer_pkg::PH_IDLE && w.start_req) begin
      m_phase   = uer_pkg::PH_TRIG;
      m_elapsed = '0;
    end
    if (m_phase == uer_pkg::PH_TRIG) begin
      trig = 1'b1;
      if (m_elapsed != uer_pkg::Sat16) m_elapsed++;
      // a zero trigger length ends the pulse after one tick, same as one
      if (m_elapsed >= cfg_m.trigger_ticks) begin
        m_phase   = uer_pkg::PH_WAIT;
        m_elapsed = '0;
      end
    end else if (m_phase == uer_pkg::PH_WAIT || m_phase == uer_pkg::PH_HIGH) begin
      if (m_phase == uer_pkg::PH_HIGH && !w.echo_level) begin
        // falling edge ends the measurement, even on the timeout tick
        m_dist  = m_cm;
        m_zone  = zone_of(m_cm);
        m_phase = uer_pkg::PH_IDLE;
        done    = 1'b1;
      end else begin
        if (w.echo_level) begin
          if (m_phase == uer_pkg::PH_WAIT) begin
            m_phase = uer_pkg::PH_HIGH;
            m_frac  = '0;
            m_cm    = '0;
          end
          if (int'(m_frac) + 1 >= int'(cfg_m.ticks_per_cm)) begin
            m_frac = '0;
            if (m_cm != uer_pkg::Sat16) m_cm++;
          end else begin
            m_frac++;
          end
        end
        if (m_elapsed != uer_pkg::Sat16) m_elapsed++;
        if (m_elapsed >= cfg_m.timeout_ticks) begin
          m_dist  = '0;
          m_zone  = uer_pkg::ZONE_NONE;
          m_phase = uer_pkg::PH_IDLE;
          done    = 1'b1;
        end
      end
    end
    r.trigger_out = trig;
    r.busy_res    = (m_phase != uer_pkg::PH_IDLE);
    r.done_res    = done;
    r.distance_cm = m_dist;
    r.no_object   = (m_zone == uer_pkg::ZONE_NONE);
    r.zone        = m_zone;
    r.led_green   = (m_zone == uer_pkg::ZONE_APPROACH || m_zone == uer_pkg::ZONE_WARNING ||
                     m_zone == uer_pkg::ZONE_STOP);
    r.led_yellow  = (m_zone == uer_pkg::ZONE_WARNING || m_zone == uer_pkg::ZONE_STOP);
    r.led_red     = (m_zone == uer_pkg::ZONE_STOP);
    return r;
  endfunction

  function automatic void note_mismatch(string msg);
    if (mismatch_n < 10) $display("ERROR: %s", msg);
    mismatch_n++;
  endfunction

  // --------------------------------------------------------------------------
  // Tick driver: one word per handshake, a random gap drawn after each word.
  // The mirror is stepped at the edge that takes the word.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : tick_driver
    int unsigned       gap_n;
    logic              valid_n;
    uer_pkg::in_word_t data_n;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_gap     <= 0;
    end else begin
      valid_n = in_valid_i;
      data_n  = in_data_i;
      gap_n   = tx_gap;
      if (in_valid_i && in_ready_o) begin
        report_q.push_back(predict_tick(in_data_i));
        valid_n = 1'b0;
        gap_n   = $urandom_range(0, tx_max);
      end
      if (!valid_n) begin
        if (gap_n != 0) begin
          gap_n--;
        end else if (tick_q.size() != 0) begin
          valid_n = 1'b1;
          data_n  = tick_q.pop_front();
        end
      end
      // single update per signal: valid stays high across back-to-back words
      in_valid_i <= valid_n;
      in_data_i  <= data_n;
      tx_gap     <= gap_n;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks every accepted result word against the oldest
  // expectation, field by field, and stalls ready at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int unsigned        stall_n;
    uer_pkg::out_word_t want;
    string              bad;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall    <= 0;
    end else begin
      stall_n = (rx_stall != 0) ? rx_stall - 1 : 0;
      if (out_valid_o && out_ready_i) begin
        stall_n = $urandom_range(0, rx_max);
        if (report_q.size() == 0) begin
          note_mismatch($sformatf("result word %h with nothing expected", out_data_o));
        end else begin
          want = report_q.pop_front();
          bad  = "";
          if (out_data_o.trigger_out !== want.trigger_out) bad = {bad, " trigger_out"};
          if (out_data_o.busy_res !== want.busy_res)       bad = {bad, " busy_res"};
          if (out_data_o.done_res !== want.done_res)       bad = {bad, " done_res"};
          if (out_data_o.distance_cm !== want.distance_cm) bad = {bad, " distance_cm"};
          if (out_data_o.no_object !== want.no_object)     bad = {bad, " no_object"};
          if (out_data_o.zone !== want.zone)               bad = {bad, " zone"};
          if (out_data_o.led_green !== want.led_green)     bad = {bad, " led_green"};
          if (out_data_o.led_yellow !== want.led_yellow)   bad = {bad, " led_yellow"};
          if (out_data_o.led_red !== want.led_red)         bad = {bad, " led_red"};
          if (bad != "") begin
            note_mismatch($sformatf("result word: expected %h, got %h, differs in%s",
                                    want, out_data_o, bad));
          end
        end
      end
      rx_stall    <= stall_n;
      out_ready_i <= (stall_n == 0) && !rx_hold;
    end
  end

  // Long receiver hold-off while the sender keeps offering words: the
  // result register fills and in_ready_o must drop.
  initial begin : rx_hold_off
    wait (hold_go);
    repeat (4) @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (120) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic put_tick(bit s, bit e);
    tick_q.push_back(uer_pkg::in_word_t'{start_req: s, echo_level: e});
    work_n++;
  endtask

  // wait until the driver is empty and every expected result word is in
  task automatic wait_drained();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || report_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [uer_pkg::CfgIdxBits-1:0] idx,
                           input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      uer_pkg::CFG_TRIGGER_TICKS: cfg_m.trigger_ticks = data[7:0];
      uer_pkg::CFG_TIMEOUT_TICKS: cfg_m.timeout_ticks = data;
      uer_pkg::CFG_TICKS_PER_CM:  cfg_m.ticks_per_cm  = data[5:0];
      uer_pkg::CFG_FAR_LIMIT:     cfg_m.far_limit     = data;
      uer_pkg::CFG_MID_LIMIT:     cfg_m.mid_limit     = data;
      uer_pkg::CFG_NEAR_LIMIT:    cfg_m.near_limit    = data;
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [15:0] trig_d, tmo_d, tpc_d, far_d, mid_d,
                              near_d);
    write_reg(uer_pkg::CFG_TRIGGER_TICKS, trig_d);
    write_reg(uer_pkg::CFG_TIMEOUT_TICKS, tmo_d);
    write_reg(uer_pkg::CFG_TICKS_PER_CM, tpc_d);
    write_reg(uer_pkg::CFG_FAR_LIMIT, far_d);
    write_reg(uer_pkg::CFG_MID_LIMIT, mid_d);
    write_reg(uer_pkg::CFG_NEAR_LIMIT, near_d);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One well-formed measurement: start, rest of the trigger pulse, lo_n low
  // echo ticks, hi_n high ticks, then the falling tick. Watch ticks are cut
  // at the timeout, so a run that reaches it ends with no falling tick.
  // Start bits on busy ticks are random and must be ignored.
  task automatic queue_measurement(int unsigned lo_n, int unsigned hi_n);
    int unsigned trig_n;
    int unsigned tmo;
    int unsigned n;
    trig_n = (cfg_m.trigger_ticks == 0) ? 1 : cfg_m.trigger_ticks;
    tmo    = (cfg_m.timeout_ticks == 0) ? 1 : cfg_m.timeout_ticks;
    n      = 0;
    put_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (trig_n - 1) put_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    while (n < lo_n && n < tmo) begin
      put_tick(1'($urandom_range(0, 1)), 1'b0);
      n++;
    end
    while (n < lo_n + hi_n && n < tmo) begin
      put_tick(1'($urandom_range(0, 1)), 1'b1);
      n++;
    end
    if (n < tmo) put_tick(1'($urandom_range(0, 1)), 1'b0);
  endtask

  // random junk, then enough quiet ticks to bring the block back to idle
  task automatic queue_noise();
    int unsigned trig_n;
    int unsigned tmo;
    trig_n = (cfg_m.trigger_ticks == 0) ? 1 : cfg_m.trigger_ticks;
    tmo    = (cfg_m.timeout_ticks == 0) ? 1 : cfg_m.timeout_ticks;
    repeat ($urandom_range(3, 12)) begin
      put_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    repeat (trig_n + tmo + 1) put_tick(1'b0, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned p;
    int unsigned phase_end;
    int unsigned kind;
    int unsigned trig_v;
    int unsigned tpc_v;
    int unsigned tpc_eff;
    int unsigned tmo_v;
    int unsigned tmo_eff;
    int unsigned span;
    int unsigned hi_max;
    logic [15:0] far_v;
    logic [15:0] mid_v;
    logic [15:0] near_v;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle words at reset values, then short measurements with a
    // one-tick trigger, timeout 6, 1 tick/cm, limits 3/2/1.
    tx_max = 3;
    rx_max = 3;
    put_tick(1'b0, 1'b1);
    put_tick(1'b0, 1'b0);
    wait_drained();
    load_setting(16'd1, 16'd6, 16'd1, 16'd3, 16'd2, 16'd1);
    @(negedge clk_i);
    queue_measurement(0, 5);   // falling edge on the timeout tick wins: 5 cm, clear
    queue_measurement(0, 2);   // 2 cm, warning
    queue_measurement(0, 1);   // 1 cm, stop
    queue_measurement(0, 6);   // echo still high at the timeout: no object

    // Random phases. Each starts from an empty pipe (the sender waits for
    // every result), loads a setting, then queues measurements.
    work_n = 0;
    p      = 0;
    while (work_n < WorkTicks) begin
      wait_drained();
      case (p)
        0: begin
          // all-zero registers: trigger, timeout and ticks/cm each act as one
          trig_v = 0; tmo_v = 0; tpc_v = 0;
          far_v  = '0; mid_v = '0; near_v = '0;
        end
        1: begin
          trig_v = 255; tmo_v = 65535; tpc_v = 63;
          far_v  = '1; mid_v = '1; near_v = '1;
        end
        2: begin
          trig_v = int'(uer_pkg::TriggerTicksRst);
          tmo_v  = int'(uer_pkg::TimeoutTicksRst);
          tpc_v  = int'(uer_pkg::TicksPerCmRst);
          far_v  = uer_pkg::FarLimitRst;
          mid_v  = uer_pkg::MidLimitRst;
          near_v = uer_pkg::NearLimitRst;
        end
        default: begin
          trig_v = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
          tpc_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 4);
          near_v = 16'($urandom_range(0, 6));
          mid_v  = 16'(near_v + $urandom_range(0, 6));
          far_v  = 16'(mid_v + $urandom_range(0, 6));
          if ($urandom_range(0, 3) == 0) begin
            // misordered limits
            far_v  = 16'($urandom_range(0, 15));
            mid_v  = 16'($urandom_range(0, 15));
            near_v = 16'($urandom_range(0, 15));
          end
          if ($urandom_range(0, 7) == 0) far_v = 16'($urandom);
          if ($urandom_range(0, 7) == 0) mid_v = 16'($urandom);
          if ($urandom_range(0, 7) == 0) near_v = 16'($urandom);
        end
      endcase
      tpc_eff = (tpc_v == 0) ? 1 : tpc_v;
      span    = (far_v < 40) ? far_v + 3 : 8;
      hi_max  = tpc_eff * span;
      if (hi_max > 600) hi_max = 600;
      if (p > 2) begin
        tmo_v = ($urandom_range(0, 7) == 0) ? 16'($urandom) : $urandom_range(1, hi_max + 8);
      end
      tmo_eff = (tmo_v == 0) ? 1 : tmo_v;

      // junk in the unused upper data bits of the narrow registers
      load_setting({8'($urandom), 8'(trig_v)}, 16'(tmo_v), {10'($urandom), 6'(tpc_v)},
                   far_v, mid_v, near_v);
      @(negedge clk_i);
      if (p == 3) begin
        // back-to-back words under the long receiver hold-off
        tx_max  = 0;
        rx_max  = 0;
        hold_go = 1'b1;
      end else begin
        tx_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
        rx_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      end

      phase_end = work_n + 150;
      while (work_n < phase_end) begin
        kind = $urandom_range(0, 9);
        if (kind == 0 && tmo_eff <= 100) begin
          queue_noise();
        end else if (kind == 1 && tmo_eff <= 200) begin
          queue_measurement(tmo_eff, 0);   // no echo at all
        end else begin
          queue_measurement($urandom_range(0, 3), $urandom_range(1, hi_max));
        end
        // idle words between measurements; echo is don't-care here
        repeat ($urandom_range(0, 2)) begin
          tick_q.push_back(uer_pkg::in_word_t'{start_req: 1'b0,
                                               echo_level: 1'($urandom_range(0, 1))});
        end
      end
      p++;
    end

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (report_q.size() != 0) begin
      note_mismatch($sformatf("%0d result words never arrived", report_q.size()));
    end
    if (mismatch_n == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
